>>> rtl/core/teq_pkg.sv
// Shared constants, codes and types of the timer expiry queue.
`timescale 1ns / 1ps

package teq_pkg;

    localparam int MaxTimers  = 16;
    localparam int MaxResults = 16;
    localparam int IdxW       = $clog2(MaxTimers);
    localparam int ResIdxW    = $clog2(MaxResults);
    localparam int CntW       = $clog2(MaxResults + 1);
    localparam int IdW        = 16;
    localparam int TimeW      = 32;
    localparam int IvW        = 31;

    localparam logic [1:0] CmdAdd    = 2'd0;
    localparam logic [1:0] CmdRemove = 2'd1;
    localparam logic [1:0] CmdTick   = 2'd2;

    localparam logic [1:0] KindAdd    = 2'd0;
    localparam logic [1:0] KindRemove = 2'd1;
    localparam logic [1:0] KindExpire = 2'd2;

    localparam logic [1:0] StatOk       = 2'd0;
    localparam logic [1:0] StatFull     = 2'd1;
    localparam logic [1:0] StatNotFound = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] deadline;
        logic [IvW-1:0]   interval;
        logic             periodic;
    } entry_t;

    // One table update per cycle: add fills a slot, clear drops it,
    // rearm rewrites only the deadline.
    typedef struct packed {
        logic             add;
        logic             clear;
        logic             rearm;
        logic [IdxW-1:0]  idx;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] deadline;
        logic [IvW-1:0]   interval;
        logic             periodic;
    } wr_t;

endpackage

>>> rtl/core/teq_if.sv
// Request and result channel interfaces of the timer expiry queue.
`timescale 1ns / 1ps

interface teq_in_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic [teq_pkg::IvW-1:0] interval_ms;
    logic                    periodic;
    logic [teq_pkg::IdW-1:0] timer_id;

    modport source (output valid, cmd, interval_ms, periodic, timer_id, input ready);
    modport sink (input valid, cmd, interval_ms, periodic, timer_id, output ready);
endinterface

interface teq_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [teq_pkg::IdW-1:0]   timer_id_res;
    logic [1:0]                status;
    logic                      rearmed;
    logic [teq_pkg::TimeW-1:0] ms_to_next;
    logic                      last;

    modport source (output valid, kind, timer_id_res, status, rearmed, ms_to_next, last,
                    input ready);
    modport sink (input valid, kind, timer_id_res, status, rearmed, ms_to_next, last,
                  output ready);
endinterface

>>> rtl/core/teq_table.sv
// Timer table: per-slot id, deadline, interval, periodic flag and valid bits.
`timescale 1ns / 1ps

module teq_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [teq_pkg::IdxW-1:0]     rd_idx,
    output teq_pkg::entry_t              rd,
    output logic [teq_pkg::MaxTimers-1:0] vbits,
    input  teq_pkg::wr_t                 wr
);

    logic [teq_pkg::MaxTimers-1:0] valid_reg;
    logic [teq_pkg::IdW-1:0]       id_reg       [teq_pkg::MaxTimers];
    logic [teq_pkg::TimeW-1:0]     deadline_reg [teq_pkg::MaxTimers];
    logic [teq_pkg::IvW-1:0]       interval_reg [teq_pkg::MaxTimers];
    logic                          periodic_reg [teq_pkg::MaxTimers];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.add)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
        else if (wr.clear)
        begin
            valid_reg[wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.add)
        begin
            id_reg[wr.idx]       <= wr.id;
            deadline_reg[wr.idx] <= wr.deadline;
            interval_reg[wr.idx] <= wr.interval;
            periodic_reg[wr.idx] <= wr.periodic;
        end
        else if (wr.rearm)
        begin
            deadline_reg[wr.idx] <= wr.deadline;
        end
    end

    assign rd.valid    = valid_reg[rd_idx];
    assign rd.id       = id_reg[rd_idx];
    assign rd.deadline = deadline_reg[rd_idx];
    assign rd.interval = interval_reg[rd_idx];
    assign rd.periodic = periodic_reg[rd_idx];
    assign vbits       = valid_reg;

endmodule

>>> rtl/core/timer_expiry_queue.sv
// Top level: command sequencer, shared slot-scan unit and result buffer.
//
//   channel   dir   handshake     contents
//   in_req    in    valid/ready   cmd, interval_ms, periodic, timer_id
//   out_res   out   valid/ready   kind, timer_id_res, status, rearmed, ms_to_next, last
//
// One slot of the table is examined per cycle by a single subtract/compare unit.
// Add: accept, then one scan for the earliest deadline; remove: one scan to find the id,
// then one for the earliest deadline; tick: one full scan per reported expiry, one to
// find none left unless the result limit is hit, and one for the earliest deadline;
// each result is then delivered through the output register.
// Reset clears the clock, the id counter and all valid bits; no clearing pass.
// A new request is taken only after the last result of the previous one has been
// loaded into the output register; a stalled output holds the sequencer.
`timescale 1ns / 1ps

module timer_expiry_queue (
    input  logic clk,
    input  logic rst_n,
    teq_in_if.sink    in_req,
    teq_out_if.source out_res
);

    typedef enum logic [3:0] {
        StIdle = 4'b0001,
        StFind = 4'b0010,
        StMin  = 4'b0100,
        StEmit = 4'b1000
    } state_t;

    localparam logic [teq_pkg::TimeW-1:0] SignBit = {1'b1, {(teq_pkg::TimeW-1){1'b0}}};

    state_t state_reg, state_next;
    logic [teq_pkg::IdxW-1:0]    scan_reg, scan_next;
    logic [teq_pkg::TimeW-1:0]   now_reg, now_next;
    logic [teq_pkg::IdW-1:0]     last_id_reg, last_id_next;
    logic [1:0]                  cmd_reg, cmd_next;
    logic [teq_pkg::IdW-1:0]     rid_reg, rid_next;
    logic                        found_reg, found_next;
    logic                        bfound_reg, bfound_next;
    logic [teq_pkg::TimeW-1:0]   bgap_reg, bgap_next;
    logic [teq_pkg::IdW-1:0]     bid_reg, bid_next;
    logic [teq_pkg::IdxW-1:0]    bidx_reg, bidx_next;
    logic [teq_pkg::IvW-1:0]     biv_reg, biv_next;
    logic                        bper_reg, bper_next;
    logic [teq_pkg::TimeW-1:0]   min_reg, min_next;
    logic [teq_pkg::CntW-1:0]    cnt_reg, cnt_next;
    logic [teq_pkg::ResIdxW-1:0] emit_reg, emit_next;
    logic [1:0]                  status_reg, status_next;

    logic [teq_pkg::IdW-1:0]     res_id_reg [teq_pkg::MaxResults];
    logic                        res_rearm_reg [teq_pkg::MaxResults];
    logic                        buf_we;
    logic [teq_pkg::ResIdxW-1:0] buf_idx;
    logic [teq_pkg::IdW-1:0]     buf_id;
    logic                        buf_rearm;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_load;
    logic [1:0]                out_kind_reg;
    logic [teq_pkg::IdW-1:0]   out_id_reg;
    logic [1:0]                out_status_reg;
    logic                      out_rearm_reg;
    logic [teq_pkg::TimeW-1:0] out_ms_reg;
    logic                      out_last_reg;
    logic [1:0]                emit_kind;
    logic                      emit_last;

    teq_pkg::entry_t           rd;
    logic [teq_pkg::MaxTimers-1:0] vbits;
    teq_pkg::wr_t              wr;

    logic                      in_acc;
    logic [teq_pkg::TimeW-1:0] gap, bgap, clamp;
    logic                      is_exp, better, take, match, last_scan;
    logic                      fin_found;
    logic [teq_pkg::IdxW-1:0]  fin_idx;
    logic [teq_pkg::IdW-1:0]   fin_id;
    logic [teq_pkg::IvW-1:0]   fin_iv;
    logic                      fin_per;
    logic [teq_pkg::TimeW-1:0] fin_min;
    logic [teq_pkg::IdxW-1:0]  free_idx;
    logic                      full;
    logic [teq_pkg::IvW-1:0]   add_iv;
    logic [teq_pkg::IdW-1:0]   new_id;

    teq_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (scan_reg),
        .rd     (rd),
        .vbits  (vbits),
        .wr     (wr)
    );

    assign in_req.ready = (state_reg == StIdle);
    assign in_acc       = in_req.valid && in_req.ready;

    // shared scan unit: wrap-safe distance of the current slot's deadline
    assign gap       = rd.deadline - now_reg;
    assign bgap      = gap ^ SignBit;
    assign is_exp    = rd.valid && ((gap == '0) || gap[teq_pkg::TimeW-1]);
    assign better    = !bfound_reg || (bgap < bgap_reg)
                       || ((bgap == bgap_reg) && (rd.id < bid_reg));
    assign take      = is_exp && better;
    assign match     = rd.valid && (rd.id == rid_reg) && (rid_reg != '0) && !found_reg;
    assign clamp     = gap[teq_pkg::TimeW-1] ? '0 : gap;
    assign fin_min   = (rd.valid && (clamp < min_reg)) ? clamp : min_reg;
    assign last_scan = (scan_reg == teq_pkg::IdxW'(teq_pkg::MaxTimers - 1));

    assign fin_found = bfound_reg || take;
    assign fin_idx   = take ? scan_reg    : bidx_reg;
    assign fin_id    = take ? rd.id       : bid_reg;
    assign fin_iv    = take ? rd.interval : biv_reg;
    assign fin_per   = take ? rd.periodic : bper_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = teq_pkg::MaxTimers - 1; i >= 0; i--)
        begin
            if (!vbits[i])
            begin
                free_idx = teq_pkg::IdxW'(i);
            end
        end
    end

    assign full   = &vbits;
    assign add_iv = (in_req.interval_ms == '0) ? teq_pkg::IvW'(1) : in_req.interval_ms;
    assign new_id = ((last_id_reg + 1'b1) == '0) ? teq_pkg::IdW'(1) : (last_id_reg + 1'b1);

    always_comb
    begin
        case (cmd_reg)
            teq_pkg::CmdAdd:    emit_kind = teq_pkg::KindAdd;
            teq_pkg::CmdRemove: emit_kind = teq_pkg::KindRemove;
            default:            emit_kind = teq_pkg::KindExpire;
        endcase
    end

    assign emit_last = ({1'b0, emit_reg} == (cnt_reg - 1'b1));
    assign out_load  = (state_reg == StEmit) && (!out_valid_reg || out_res.ready);

    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        now_next     = now_reg;
        last_id_next = last_id_reg;
        cmd_next     = cmd_reg;
        rid_next     = rid_reg;
        found_next   = found_reg;
        bfound_next  = bfound_reg;
        bgap_next    = bgap_reg;
        bid_next     = bid_reg;
        bidx_next    = bidx_reg;
        biv_next     = biv_reg;
        bper_next    = bper_reg;
        min_next     = min_reg;
        cnt_next     = cnt_reg;
        emit_next    = emit_reg;
        status_next  = status_reg;
        buf_we       = 1'b0;
        buf_idx      = '0;
        buf_id       = '0;
        buf_rearm    = 1'b0;
        wr           = '0;

        case (state_reg)
            StIdle:
            begin
                if (in_acc)
                begin
                    cmd_next    = in_req.cmd;
                    rid_next    = in_req.timer_id;
                    scan_next   = '0;
                    found_next  = 1'b0;
                    bfound_next = 1'b0;
                    cnt_next    = '0;
                    min_next    = '1;
                    case (in_req.cmd)
                        teq_pkg::CmdAdd:
                        begin
                            buf_we   = 1'b1;
                            cnt_next = teq_pkg::CntW'(1);
                            if (full)
                            begin
                                status_next = teq_pkg::StatFull;
                            end
                            else
                            begin
                                status_next  = teq_pkg::StatOk;
                                last_id_next = new_id;
                                buf_id       = new_id;
                                wr.add       = 1'b1;
                                wr.idx       = free_idx;
                                wr.id        = new_id;
                                wr.interval  = add_iv;
                                wr.periodic  = in_req.periodic;
                                wr.deadline  = now_reg + {1'b0, add_iv};
                            end
                            state_next = StMin;
                        end
                        teq_pkg::CmdRemove:
                        begin
                            state_next = StFind;
                        end
                        teq_pkg::CmdTick:
                        begin
                            now_next    = now_reg + 1'b1;
                            status_next = teq_pkg::StatOk;
                            state_next  = StFind;
                        end
                        default:
                        begin
                            state_next = StIdle;
                        end
                    endcase
                end
            end

            StFind:
            begin
                scan_next = scan_reg + 1'b1;
                if (cmd_reg == teq_pkg::CmdRemove)
                begin
                    if (match)
                    begin
                        found_next = 1'b1;
                        wr.clear   = 1'b1;
                        wr.idx     = scan_reg;
                    end
                    if (last_scan)
                    begin
                        buf_we      = 1'b1;
                        buf_id      = (found_reg || match) ? rid_reg : '0;
                        status_next = (found_reg || match) ? teq_pkg::StatOk
                                                           : teq_pkg::StatNotFound;
                        cnt_next    = teq_pkg::CntW'(1);
                        min_next    = '1;
                        state_next  = StMin;
                    end
                end
                else
                begin
                    if (take)
                    begin
                        bfound_next = 1'b1;
                        bgap_next   = bgap;
                        bid_next    = rd.id;
                        bidx_next   = scan_reg;
                        biv_next    = rd.interval;
                        bper_next   = rd.periodic;
                    end
                    if (last_scan)
                    begin
                        bfound_next = 1'b0;
                        if (fin_found)
                        begin
                            buf_we    = 1'b1;
                            buf_idx   = cnt_reg[teq_pkg::ResIdxW-1:0];
                            buf_id    = fin_id;
                            buf_rearm = fin_per;
                            wr.idx    = fin_idx;
                            if (fin_per)
                            begin
                                wr.rearm    = 1'b1;
                                wr.deadline = now_reg + {1'b0, fin_iv};
                            end
                            else
                            begin
                                wr.clear = 1'b1;
                            end
                            cnt_next = cnt_reg + 1'b1;
                            if ((cnt_reg + 1'b1) == teq_pkg::CntW'(teq_pkg::MaxResults))
                            begin
                                min_next   = '1;
                                state_next = StMin;
                            end
                        end
                        else
                        begin
                            min_next   = '1;
                            state_next = StMin;
                        end
                    end
                end
            end

            StMin:
            begin
                scan_next = scan_reg + 1'b1;
                min_next  = fin_min;
                if (last_scan)
                begin
                    emit_next  = '0;
                    state_next = (cnt_reg == '0) ? StIdle : StEmit;
                end
            end

            StEmit:
            begin
                if (out_load)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (emit_last)
                    begin
                        state_next = StIdle;
                    end
                end
            end

            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            scan_reg      <= '0;
            now_reg       <= '0;
            last_id_reg   <= '0;
            found_reg     <= 1'b0;
            bfound_reg    <= 1'b0;
            cnt_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            now_reg       <= now_next;
            last_id_reg   <= last_id_next;
            found_reg     <= found_next;
            bfound_reg    <= bfound_next;
            cnt_reg       <= cnt_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rid_reg    <= rid_next;
        bgap_reg   <= bgap_next;
        bid_reg    <= bid_next;
        bidx_reg   <= bidx_next;
        biv_reg    <= biv_next;
        bper_reg   <= bper_next;
        min_reg    <= min_next;
        status_reg <= status_next;
        if (buf_we)
        begin
            res_id_reg[buf_idx]    <= buf_id;
            res_rearm_reg[buf_idx] <= buf_rearm;
        end
        if (out_load)
        begin
            out_kind_reg   <= emit_kind;
            out_id_reg     <= res_id_reg[emit_reg];
            out_status_reg <= status_reg;
            out_rearm_reg  <= res_rearm_reg[emit_reg];
            out_ms_reg     <= min_reg;
            out_last_reg   <= emit_last;
        end
    end

    assign out_res.valid        = out_valid_reg;
    assign out_res.kind         = out_kind_reg;
    assign out_res.timer_id_res = out_id_reg;
    assign out_res.status       = out_status_reg;
    assign out_res.rearmed      = out_rearm_reg;
    assign out_res.ms_to_next   = out_ms_reg;
    assign out_res.last         = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= teq_pkg::CntW'(teq_pkg::MaxResults))
        else $error("result count beyond buffer depth");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StEmit) |-> (cnt_reg != '0))
        else $error("emit with empty result buffer");

    a_add_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_req.cmd == teq_pkg::CmdAdd) && !full)
        |=> ($countones(vbits) == $past($countones(vbits)) + 1))
        else $error("add did not occupy a slot");

    a_tick_now: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_req.cmd == teq_pkg::CmdTick)) |=> (now_reg == $past(now_reg) + 1'b1))
        else $error("tick did not advance clock");

endmodule

>>> verif/timer_expiry_queue_tb.sv
// Self-checking testbench of the timer expiry queue: directed table, then random traffic.
`timescale 1ns / 1ps

module timer_expiry_queue_tb;

    // cmd 3 is unused: no state change, no result
    localparam logic [1:0] CmdIdle = 2'd3;
    localparam int MaxIdle = 12;
    localparam int RandItems = 440;

    typedef struct {
        logic [1:0]              cmd;
        logic [teq_pkg::IvW-1:0] interval;
        logic                    periodic;
        logic [teq_pkg::IdW-1:0] id;
        bit                      typed;      // first result typed in below
        logic [1:0]              t_kind;
        logic [teq_pkg::IdW-1:0] t_id;
        logic [1:0]              t_status;
    } stim_t;

    typedef struct {
        logic [1:0]                kind;
        logic [teq_pkg::IdW-1:0]   id;
        logic [1:0]                status;
        logic                      rearmed;
        logic [teq_pkg::TimeW-1:0] next;
        logic                      last;
    } res_t;

    logic clk;
    logic rst_n;

    teq_in_if  in_req ();
    teq_out_if out_res ();

    timer_expiry_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req),
        .out_res (out_res)
    );

    // shadow copy of the timer table
    logic [teq_pkg::TimeW-1:0] clock_ms;
    logic [teq_pkg::IdW-1:0]   id_counter;
    logic                      tv [teq_pkg::MaxTimers];
    logic [teq_pkg::IdW-1:0]   tid [teq_pkg::MaxTimers];
    logic [teq_pkg::TimeW-1:0] tdl [teq_pkg::MaxTimers];
    logic [teq_pkg::IvW-1:0]   tiv [teq_pkg::MaxTimers];
    logic                      tper [teq_pkg::MaxTimers];

    res_t  pending_res[$];
    res_t  step_res[$];
    stim_t table_rows[$];
    int    errors;
    int    n_add, n_rem, n_tick, n_exp, n_full, n_res;
    bit    sending_done;
    bit    idle_on;

    function automatic bit is_due(logic [teq_pkg::TimeW-1:0] dl);
        logic [teq_pkg::TimeW-1:0] d;
        d = dl - clock_ms;
        return (d == '0) || d[teq_pkg::TimeW-1];
    endfunction

    // expected results of one request, written to step_res after clearing it
    function automatic void predict_step(stim_t s);
        int slot;
        int best;
        logic [teq_pkg::TimeW-1:0] gi, gb, d, nearest;
        logic [teq_pkg::IvW-1:0] iv;
        res_t r;
        step_res.delete();
        r = '{default: '0};
        if (s.cmd == teq_pkg::CmdAdd) begin
            slot = -1;
            for (int i = 0; i < teq_pkg::MaxTimers; i++)
                if (!tv[i] && slot < 0) slot = i;
            r.kind = teq_pkg::KindAdd;
            if (slot < 0) begin
                r.status = teq_pkg::StatFull;
                n_full++;
            end else begin
                id_counter = id_counter + 1'b1;
                if (id_counter == '0) id_counter = teq_pkg::IdW'(1);
                iv = (s.interval == '0) ? teq_pkg::IvW'(1) : s.interval;
                tv[slot] = 1'b1;
                tid[slot] = id_counter;
                tiv[slot] = iv;
                tper[slot] = s.periodic;
                tdl[slot] = clock_ms + {1'b0, iv};
                r.id = id_counter;
                r.status = teq_pkg::StatOk;
            end
            step_res.push_back(r);
        end else if (s.cmd == teq_pkg::CmdRemove) begin
            slot = -1;
            if (s.id != '0)
                for (int i = 0; i < teq_pkg::MaxTimers; i++)
                    if (slot < 0 && tv[i] && tid[i] == s.id) slot = i;
            r.kind = teq_pkg::KindRemove;
            if (slot < 0) begin
                r.status = teq_pkg::StatNotFound;
            end else begin
                tv[slot] = 1'b0;
                r.id = s.id;
            end
            step_res.push_back(r);
        end else if (s.cmd == teq_pkg::CmdTick) begin
            clock_ms = clock_ms + 1'b1;
            while (step_res.size() < teq_pkg::MaxResults) begin
                best = -1;
                for (int i = 0; i < teq_pkg::MaxTimers; i++) begin
                    if (tv[i] && is_due(tdl[i])) begin
                        if (best < 0) begin
                            best = i;
                        end else begin
                            gi = (tdl[i] - clock_ms) ^ 32'h8000_0000;
                            gb = (tdl[best] - clock_ms) ^ 32'h8000_0000;
                            if (gi < gb || (gi == gb && tid[i] < tid[best])) best = i;
                        end
                    end
                end
                if (best < 0) break;
                r = '{default: '0};
                r.kind = teq_pkg::KindExpire;
                r.id = tid[best];
                r.status = teq_pkg::StatOk;
                if (tper[best]) begin
                    tdl[best] = clock_ms + {1'b0, tiv[best]};
                    r.rearmed = 1'b1;
                end else begin
                    tv[best] = 1'b0;
                end
                step_res.push_back(r);
                n_exp++;
            end
        end
        nearest = '1;
        for (int i = 0; i < teq_pkg::MaxTimers; i++) begin
            if (tv[i]) begin
                d = tdl[i] - clock_ms;
                if (d[teq_pkg::TimeW-1]) d = '0;
                if (d < nearest) nearest = d;
            end
        end
        foreach (step_res[k]) begin
            step_res[k].next = nearest;
            step_res[k].last = (k == step_res.size() - 1);
        end
    endfunction

    function automatic stim_t mk(logic [1:0] c, int unsigned iv, int unsigned p,
                                 int unsigned id);
        stim_t s;
        s = '{default: '0};
        s.cmd = c;
        s.interval = teq_pkg::IvW'(iv);
        s.periodic = p[0];
        s.id = teq_pkg::IdW'(id);
        return s;
    endfunction

    function automatic stim_t mk_typed(stim_t s, logic [1:0] k, int unsigned id,
                                       logic [1:0] st);
        s.typed = 1'b1;
        s.t_kind = k;
        s.t_id = teq_pkg::IdW'(id);
        s.t_status = st;
        return s;
    endfunction

    function automatic stim_t rand_req();
        int pick;
        int live[$];
        pick = $urandom_range(99);
        if (pick < 30) begin
            pick = $urandom_range(99);
            if (pick < 4)
                return mk(teq_pkg::CmdAdd, 0, $urandom_range(1), 0);
            else if (pick < 12)
                return mk(teq_pkg::CmdAdd, $urandom, $urandom_range(1), $urandom);
            return mk(teq_pkg::CmdAdd, $urandom_range(30, 1), $urandom_range(1), $urandom);
        end else if (pick < 48) begin
            for (int i = 0; i < teq_pkg::MaxTimers; i++)
                if (tv[i]) live.push_back(i);
            if (live.size() > 0 && $urandom_range(99) < 70)
                return mk(teq_pkg::CmdRemove, $urandom, $urandom_range(1),
                          tid[live[$urandom_range(live.size() - 1)]]);
            return mk(teq_pkg::CmdRemove, $urandom, $urandom_range(1), $urandom);
        end else if (pick < 96) begin
            return mk(teq_pkg::CmdTick, $urandom, $urandom_range(1), $urandom);
        end
        return mk(CmdIdle, $urandom, $urandom_range(1), $urandom);
    endfunction

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("Timeout at %0t", $time);
        $display("Simulation FAILED");
        $finish;
    end

    // request side
    task automatic send_req(stim_t s);
        int gap;
        gap = idle_on ? $urandom_range(MaxIdle) : 0;
        if (gap > 0) begin
            in_req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_req.valid       <= 1'b1;
        in_req.cmd         <= s.cmd;
        in_req.interval_ms <= s.interval;
        in_req.periodic    <= s.periodic;
        in_req.timer_id    <= s.id;
        do @(posedge clk); while (!in_req.ready);
        predict_step(s);
        case (s.cmd)
            teq_pkg::CmdAdd:    n_add++;
            teq_pkg::CmdRemove: n_rem++;
            teq_pkg::CmdTick:   n_tick++;
            default:            ;
        endcase
        if (s.typed) begin
            if (step_res.size() == 0) begin
                $display("%0t: directed row mismatch, expected kind %0d id %0d status %0d, %s",
                         $time, s.t_kind, s.t_id, s.t_status, "actual no result");
                errors++;
            end else if (step_res[0].kind != s.t_kind || step_res[0].id != s.t_id ||
                         step_res[0].status != s.t_status) begin
                $display("%0t: directed row mismatch, expected kind %0d id %0d status %0d",
                         $time, s.t_kind, s.t_id, s.t_status);
                $display("%0t:   actual kind %0d id %0d status %0d", $time,
                         step_res[0].kind, step_res[0].id, step_res[0].status);
                errors++;
            end
        end
        foreach (step_res[k]) pending_res.push_back(step_res[k]);
    endtask

    initial begin
        int waited;
        errors = 0;
        n_add = 0; n_rem = 0; n_tick = 0; n_exp = 0; n_full = 0; n_res = 0;
        sending_done = 1'b0;
        idle_on = 1'b1;
        clock_ms = '0;
        id_counter = '0;
        for (int i = 0; i < teq_pkg::MaxTimers; i++) tv[i] = 1'b0;
        rst_n = 1'b0;
        in_req.valid = 1'b0;
        in_req.cmd = teq_pkg::CmdAdd;
        in_req.interval_ms = '0;
        in_req.periodic = 1'b0;
        in_req.timer_id = '0;

        // directed rows
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdRemove, 0, 0, 0), teq_pkg::KindRemove,
                                      0, teq_pkg::StatNotFound));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdRemove, 0, 0, 16'hFFFF),
                                      teq_pkg::KindRemove, 0, teq_pkg::StatNotFound));
        table_rows.push_back(mk(teq_pkg::CmdTick, 0, 0, 0));
        table_rows.push_back(mk(CmdIdle, 31'h7FFF_FFFF, 1, 16'hFFFF));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdAdd, 0, 0, 0), teq_pkg::KindAdd, 1,
                                      teq_pkg::StatOk));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdTick, 0, 0, 0), teq_pkg::KindExpire, 1,
                                      teq_pkg::StatOk));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdAdd, 31'h7FFF_FFFF, 1, 0),
                                      teq_pkg::KindAdd, 2, teq_pkg::StatOk));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdAdd, 2, 1, 0), teq_pkg::KindAdd, 3,
                                      teq_pkg::StatOk));
        table_rows.push_back(mk(teq_pkg::CmdTick, 0, 0, 0));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdTick, 0, 0, 0), teq_pkg::KindExpire, 3,
                                      teq_pkg::StatOk));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdRemove, 0, 0, 3), teq_pkg::KindRemove, 3,
                                      teq_pkg::StatOk));
        // fill the table, then one add too many; the fifteen new timers expire on the same tick
        for (int i = 0; i < teq_pkg::MaxTimers - 1; i++)
            table_rows.push_back(mk(teq_pkg::CmdAdd, 3, i % 2, 0));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdAdd, 3, 0, 0), teq_pkg::KindAdd, 0,
                                      teq_pkg::StatFull));
        repeat (3) table_rows.push_back(mk(teq_pkg::CmdTick, 0, 0, 0));
        table_rows.push_back(mk_typed(mk(teq_pkg::CmdRemove, 0, 0, 2), teq_pkg::KindRemove, 2,
                                      teq_pkg::StatOk));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i]) send_req(table_rows[i]);
        for (int i = 0; i < RandItems; i++) begin
            if (i % 60 == 0) idle_on = ($urandom_range(3) != 0);
            send_req(rand_req());
        end
        in_req.valid <= 1'b0;
        sending_done = 1'b1;

        waited = 0;
        while (pending_res.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (600) @(posedge clk);
        if (pending_res.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_res.size());
            errors++;
        end
        $display("Ran %0d adds (%0d refused), %0d removes, %0d ticks", n_add, n_full,
                 n_rem, n_tick);
        $display("Checked %0d results, %0d of them expiries", n_res, n_exp);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // result side
    initial begin
        int stall;
        res_t e;
        out_res.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = idle_on ? $urandom_range(MaxIdle) : 0;
            if (stall > 0) begin
                out_res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_res.ready <= 1'b1;
            do @(posedge clk); while (!out_res.valid);
            n_res++;
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d id %0d",
                         $time, out_res.kind, out_res.timer_id_res);
                errors++;
            end else begin
                e = pending_res.pop_front();
                if (out_res.kind != e.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, e.kind, out_res.kind);
                    errors++;
                end
                if (out_res.timer_id_res != e.id) begin
                    $display("%0t: timer_id_res expected %0d actual %0d", $time, e.id,
                             out_res.timer_id_res);
                    errors++;
                end
                if (out_res.status != e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             out_res.status);
                    errors++;
                end
                if (out_res.rearmed != e.rearmed) begin
                    $display("%0t: rearmed expected %0d actual %0d", $time, e.rearmed,
                             out_res.rearmed);
                    errors++;
                end
                if (out_res.ms_to_next != e.next) begin
                    $display("%0t: ms_to_next expected %0d actual %0d", $time, e.next,
                             out_res.ms_to_next);
                    errors++;
                end
                if (out_res.last != e.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last,
                             out_res.last);
                    errors++;
                end
            end
        end
    end

endmodule

>>> timer_expiry_queue.f
rtl/core/teq_pkg.sv
rtl/core/teq_if.sv
rtl/core/teq_table.sv
rtl/core/timer_expiry_queue.sv
verif/timer_expiry_queue_tb.sv
